// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SWG_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SWG_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/swiglu_pkg.sv =====
// Shared types, constants and the saturation function of the SwiGLU core.
`timescale 1ns / 1ps

package swiglu_pkg;

    localparam int WORD_W     = 32;
    localparam int TDATA_W    = 3 * WORD_W;
    localparam int NUM_STAGES = 7;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // Per-stage load enables and valid flags of the pipeline.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } swiglu_ctrl_t;

    // Clamps a signed value to the 32-bit two's complement range.
    function automatic logic [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic [WORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[WORD_W-1:0];
        end
        else if (v < SAT_MIN) begin
            r = SAT_MIN[WORD_W-1:0];
        end
        else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/swiglu_sigmoid.sv =====
// Four-segment piecewise-linear sigmoid of a signed fixed-point gate value.
`timescale 1ns / 1ps

module swiglu_sigmoid #(
    parameter int FRAC_BITS = 16
) (
    input  logic [swiglu_pkg::WORD_W-1:0] gate_value,
    output logic [FRAC_BITS:0]            sig
);
    import swiglu_pkg::*;

    localparam int SIG_W = FRAC_BITS + 1;

    localparam logic [32:0] ONE_M   = 33'd1 << FRAC_BITS;
    localparam logic [32:0] THR_HI  = 33'd5 << FRAC_BITS;
    localparam logic [32:0] THR_MID = (33'd19 << FRAC_BITS) >> 3;
    localparam logic [32:0] Y_HI    = (33'd27 << FRAC_BITS) >> 5;
    localparam logic [32:0] Y_MID   = (33'd5 << FRAC_BITS) >> 3;
    localparam logic [32:0] Y_LO    = ONE_M >> 1;

    logic [32:0] mag;
    logic [32:0] y;

    always_comb
    begin
        // The magnitude needs one extra bit for the most negative gate.
        if (gate_value[WORD_W-1]) begin
            mag = ~{gate_value[WORD_W-1], gate_value} + 33'd1;
        end
        else begin
            mag = {1'b0, gate_value};
        end

        if (mag >= THR_HI) begin
            y = ONE_M;
        end
        else if (mag >= THR_MID) begin
            y = (mag >> 5) + Y_HI;
        end
        else if (mag >= ONE_M) begin
            y = (mag >> 3) + Y_MID;
        end
        else begin
            y = (mag >> 2) + Y_LO;
        end

        // The curve is odd around one half, so negative gates mirror it.
        if (gate_value[WORD_W-1]) begin
            sig = SIG_W'(ONE_M - y);
        end
        else begin
            sig = SIG_W'(y);
        end
    end

endmodule

// ===== hw/rtl/swiglu_pipe_ctrl.sv =====
// Valid tracking and stall control for the SwiGLU datapath pipeline.
`timescale 1ns / 1ps

module swiglu_pipe_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       out_ready,
    output logic                       in_ready,
    output logic                       out_valid,
    output swiglu_pkg::swiglu_ctrl_t   ctrl
);
    import swiglu_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // A stage takes a new word when it is empty or its own word moves on,
    // so bubbles collapse and a full pipe stalls as a whole.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (!load[i]) begin
                valid_next[i] = valid_reg[i];
            end
            else begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = load[0];
    assign out_valid  = valid_reg[NUM_STAGES-1];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

// ===== hw/rtl/swiglu_activation_fwd_bwd_core.sv =====
// A word accepted on the slave side moves through stages 1 to 7 in order; stage 7 is the
// output register, from which the word is taken on the master side.
// Throughput: one word per cycle; the seven-stage multiply pipeline advances whenever
// its output register is empty or taken, and holds as a whole while it is stalled.
// The longest stage path is one 32x33 signed multiplier feeding a register.
// Reset: rst_n is asynchronous and active low; it empties the pipeline (valid flags
// only), and the block is ready to accept words as soon as it is released.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swiglu_activation_fwd_bwd_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input word fields, lowest bit up: gate_value[31:0], up_value[63:32],
    // grad_activated[95:64], all signed fixed point.
    input  logic [swiglu_pkg::TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Result word fields, lowest bit up: activated[31:0], grad_gate[63:32],
    // grad_up[95:64], all signed fixed point and saturated.
    output logic [swiglu_pkg::TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import swiglu_pkg::*;

    // Sigmoid values span [0, ONE] and need one integer bit.
    localparam int SIG_W = FRAC_BITS + 1;
    // Product of a 32-bit word and a zero-extended sigmoid value.
    localparam int PA_W  = WORD_W + SIG_W + 1;

    localparam logic [SIG_W-1:0]   ONE_S = SIG_W'(1) << FRAC_BITS;
    localparam logic signed [32:0] ONE_T = 33'sd1 <<< FRAC_BITS;

    swiglu_ctrl_t ctrl;

    // ------------------------------------------------------------------
    // Pipeline control: one valid flag per stage, load enables derived
    // back from the output handshake.
    // ------------------------------------------------------------------
    swiglu_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .ctrl      (ctrl)
    );

    // ------------------------------------------------------------------
    // Stage 1: capture the operands together with sigmoid(gate), which is
    // only compares, shifts and adds on the incoming gate.
    // ------------------------------------------------------------------
    logic [SIG_W-1:0]         sig_s1_next;
    logic signed [WORD_W-1:0] gate_s1_reg;
    logic signed [WORD_W-1:0] up_s1_reg;
    logic signed [WORD_W-1:0] grad_s1_reg;
    logic [SIG_W-1:0]         sig_s1_reg;

    swiglu_sigmoid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sigmoid (
        .gate_value (s_tdata[WORD_W-1:0]),
        .sig        (sig_s1_next)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0]) begin
            gate_s1_reg <= s_tdata[WORD_W-1:0];
            up_s1_reg   <= s_tdata[2*WORD_W-1:WORD_W];
            grad_s1_reg <= s_tdata[3*WORD_W-1:2*WORD_W];
            sig_s1_reg  <= sig_s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first row of multipliers: gate*sig for silu, gate*(1-sig)
    // for the sigmoid slope term, and grad*up for the silu gradient.
    // ------------------------------------------------------------------
    logic signed [PA_W-1:0]   silu_p_s2_next;
    logic signed [PA_W-1:0]   om_p_s2_next;
    logic signed [63:0]       gu_p_s2_next;
    logic signed [PA_W-1:0]   silu_p_s2_reg;
    logic signed [PA_W-1:0]   om_p_s2_reg;
    logic signed [63:0]       gu_p_s2_reg;
    logic signed [WORD_W-1:0] up_s2_reg;
    logic signed [WORD_W-1:0] grad_s2_reg;
    logic [SIG_W-1:0]         sig_s2_reg;

    always_comb
    begin
        silu_p_s2_next = PA_W'(gate_s1_reg) * PA_W'($signed({1'b0, sig_s1_reg}));
        om_p_s2_next   = PA_W'(gate_s1_reg) * PA_W'($signed({1'b0, ONE_S - sig_s1_reg}));
        gu_p_s2_next   = 64'(grad_s1_reg) * 64'(up_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1]) begin
            silu_p_s2_reg <= silu_p_s2_next;
            om_p_s2_reg   <= om_p_s2_next;
            gu_p_s2_reg   <= gu_p_s2_next;
            up_s2_reg     <= up_s1_reg;
            grad_s2_reg   <= grad_s1_reg;
            sig_s2_reg    <= sig_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale back. An arithmetic shift is the floor, so silu is a
    // plain part-select (it never exceeds the gate in magnitude). The silu
    // gradient saturates; t = ONE + gate*(1-sig) needs 33 bits.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] silu_s3_next;
    logic [WORD_W-1:0]        dsilu_s3_next;
    logic signed [32:0]       t_s3_next;
    logic signed [WORD_W-1:0] silu_s3_reg;
    logic signed [WORD_W-1:0] dsilu_s3_reg;
    logic signed [32:0]       t_s3_reg;
    logic signed [WORD_W-1:0] up_s3_reg;
    logic signed [WORD_W-1:0] grad_s3_reg;
    logic [SIG_W-1:0]         sig_s3_reg;

    always_comb
    begin
        silu_s3_next  = silu_p_s2_reg[FRAC_BITS +: WORD_W];
        dsilu_s3_next = sat32(gu_p_s2_reg >>> FRAC_BITS);
        t_s3_next     = $signed({om_p_s2_reg[FRAC_BITS+WORD_W-1],
                                 om_p_s2_reg[FRAC_BITS +: WORD_W]}) + ONE_T;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2]) begin
            silu_s3_reg  <= silu_s3_next;
            dsilu_s3_reg <= dsilu_s3_next;
            t_s3_reg     <= t_s3_next;
            up_s3_reg    <= up_s2_reg;
            grad_s3_reg  <= grad_s2_reg;
            sig_s3_reg   <= sig_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: second row of multipliers: silu*up, grad*silu and
    // dsilu*sig.
    // ------------------------------------------------------------------
    logic signed [63:0]     act_p_s4_next;
    logic signed [63:0]     gup_p_s4_next;
    logic signed [PA_W-1:0] q_p_s4_next;
    logic signed [63:0]     act_p_s4_reg;
    logic signed [63:0]     gup_p_s4_reg;
    logic signed [PA_W-1:0] q_p_s4_reg;
    logic signed [32:0]     t_s4_reg;

    always_comb
    begin
        act_p_s4_next = 64'(silu_s3_reg) * 64'(up_s3_reg);
        gup_p_s4_next = 64'(grad_s3_reg) * 64'(silu_s3_reg);
        q_p_s4_next   = PA_W'(dsilu_s3_reg) * PA_W'($signed({1'b0, sig_s3_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3]) begin
            act_p_s4_reg <= act_p_s4_next;
            gup_p_s4_reg <= gup_p_s4_next;
            q_p_s4_reg   <= q_p_s4_next;
            t_s4_reg     <= t_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale and saturate the forward result and the up gradient.
    // q never exceeds dsilu in magnitude, so it needs no clamp.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]        act_s5_next;
    logic [WORD_W-1:0]        gup_s5_next;
    logic signed [WORD_W-1:0] q_s5_next;
    logic [WORD_W-1:0]        act_s5_reg;
    logic [WORD_W-1:0]        gup_s5_reg;
    logic signed [WORD_W-1:0] q_s5_reg;
    logic signed [32:0]       t_s5_reg;

    always_comb
    begin
        act_s5_next = sat32(act_p_s4_reg >>> FRAC_BITS);
        gup_s5_next = sat32(gup_p_s4_reg >>> FRAC_BITS);
        q_s5_next   = q_p_s4_reg[FRAC_BITS +: WORD_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4]) begin
            act_s5_reg <= act_s5_next;
            gup_s5_reg <= gup_s5_next;
            q_s5_reg   <= q_s5_next;
            t_s5_reg   <= t_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: last multiplier, q*t, for the gate gradient.
    // ------------------------------------------------------------------
    logic signed [64:0]  gg_p_s6_next;
    logic signed [64:0]  gg_p_s6_reg;
    logic [WORD_W-1:0]   act_s6_reg;
    logic [WORD_W-1:0]   gup_s6_reg;

    always_comb
    begin
        gg_p_s6_next = 65'(q_s5_reg) * 65'(t_s5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5]) begin
            gg_p_s6_reg <= gg_p_s6_next;
            act_s6_reg  <= act_s5_reg;
            gup_s6_reg  <= gup_s5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: output register. The gate gradient is scaled and saturated;
    // after the shift it fits in 64 bits for every FRAC_BITS in range.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] gg_s7_next;
    logic [WORD_W-1:0] act_s7_reg;
    logic [WORD_W-1:0] gg_s7_reg;
    logic [WORD_W-1:0] gup_s7_reg;

    always_comb
    begin
        gg_s7_next = sat32(64'(gg_p_s6_reg >>> FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6]) begin
            act_s7_reg <= act_s6_reg;
            gg_s7_reg  <= gg_s7_next;
            gup_s7_reg <= gup_s6_reg;
        end
    end

    assign m_tdata = {gup_s7_reg, gg_s7_reg, act_s7_reg};

    // ------------------------------------------------------------------
    // Checks on the pipeline control and the sigmoid range.
    // ------------------------------------------------------------------
    `SWG_CHECK(a_empty_out_takes_input, !m_tvalid, s_tready, "empty output stalls input")
    `SWG_CHECK_NEXT(a_accept_fills_stage1, s_tvalid && s_tready, ctrl.valid[0],
        "accepted word missing from first stage")
    `SWG_CHECK(a_sig_in_range, ctrl.valid[0], sig_s1_reg <= ONE_S, "sigmoid above one")

endmodule
